// File: src/param_assign_command_parser_core_assert.svh
// Assertion macros shared by the parser RTL.
// Each macro expects a clock named clk and an active-low reset named rst_n.
`ifndef PARAM_ASSIGN_COMMAND_PARSER_CORE_ASSERT_SVH
`define PARAM_ASSIGN_COMMAND_PARSER_CORE_ASSERT_SVH

`define PACP_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define PACP_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define PACP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/pacp_pkg.sv
`default_nettype none

package pacp_pkg;

  localparam int unsigned MAX_ID_DEF      = 16;
  localparam int unsigned VALUE_CHARS_DEF = 31;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UPPER_P = 8'h50;
  localparam logic [7:0] CH_LOWER_P = 8'h70;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [14:0] INT_SAT = 15'd32767;
  localparam logic [2:0]  FRAC_DIGITS_MAX = 3'd5;

  // Weight of decimal digit d at fraction position k+1, in units of 2^-16, rounded down.
  localparam logic [15:0] FRAC_TAB [5][10] = '{
    '{16'd0, 16'd6553, 16'd13107, 16'd19660, 16'd26214,
      16'd32768, 16'd39321, 16'd45875, 16'd52428, 16'd58982},
    '{16'd0, 16'd655, 16'd1310, 16'd1966, 16'd2621,
      16'd3276, 16'd3932, 16'd4587, 16'd5242, 16'd5898},
    '{16'd0, 16'd65, 16'd131, 16'd196, 16'd262,
      16'd327, 16'd393, 16'd458, 16'd524, 16'd589},
    '{16'd0, 16'd6, 16'd13, 16'd19, 16'd26,
      16'd32, 16'd39, 16'd45, 16'd52, 16'd58},
    '{16'd0, 16'd0, 16'd1, 16'd1, 16'd2,
      16'd3, 16'd3, 16'd4, 16'd5, 16'd5}
  };

  typedef struct packed {
    logic               emit;
    logic [7:0]         id;
    logic signed [31:0] value;
  } result_t;

  function automatic logic [15:0] frac_weight(input logic [2:0] k, input logic [3:0] d);
    return FRAC_TAB[k][d];
  endfunction

endpackage

`default_nettype wire

// File: src/pacp_parser.sv
`default_nettype none

module pacp_parser #(
  parameter int unsigned MAX_ID      = pacp_pkg::MAX_ID_DEF,
  parameter int unsigned VALUE_CHARS = pacp_pkg::VALUE_CHARS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step_en,
  input  wire logic [7:0]       rx_byte,
  output pacp_pkg::result_t     result
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ID    = 2'd1,
    PH_VALUE = 2'd2
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [4:0]  count_r, count_nxt;
  logic [14:0] int_r, int_nxt;
  logic [16:0] frac_r, frac_nxt;
  logic [2:0]  fdig_r, fdig_nxt;
  logic        infrac_r, infrac_nxt;
  logic        neg_r, neg_nxt;

  logic        is_digit;
  logic [3:0]  digit;
  logic [18:0] int_prod;
  logic        value_end;
  logic [31:0] mag;

  assign is_digit  = (rx_byte >= pacp_pkg::CH_ZERO) && (rx_byte <= pacp_pkg::CH_NINE);
  assign digit     = 4'(rx_byte - pacp_pkg::CH_ZERO);
  assign int_prod  = {1'b0, int_r, 3'b000} + {3'b000, int_r, 1'b0} + {15'd0, digit};
  assign value_end = (rx_byte == pacp_pkg::CH_BANG) || (rx_byte == pacp_pkg::CH_HASH) ||
                     (count_r >= 5'(VALUE_CHARS));
  assign mag       = {1'b0, int_r, 16'h0000} + {15'd0, frac_r};

  always_comb begin
    result.emit  = (phase_r == PH_VALUE) && value_end &&
                   (id_r != 8'd0) && (id_r <= 8'(MAX_ID));
    result.id    = id_r;
    result.value = neg_r ? -$signed(mag) : $signed(mag);
  end

  always_comb begin
    phase_nxt  = phase_r;
    id_nxt     = id_r;
    count_nxt  = count_r;
    int_nxt    = int_r;
    frac_nxt   = frac_r;
    fdig_nxt   = fdig_r;
    infrac_nxt = infrac_r;
    neg_nxt    = neg_r;
    unique case (phase_r)
      PH_ID: begin
        if ((rx_byte == pacp_pkg::CH_UPPER_P) || (rx_byte == pacp_pkg::CH_LOWER_P)) begin
          id_nxt = id_r;
        end else if (is_digit) begin
          id_nxt = 8'({id_r, 3'b000} + {id_r, 1'b0} + {7'd0, digit});
        end else if (((rx_byte == pacp_pkg::CH_EQUAL) || (rx_byte == pacp_pkg::CH_COLON)) &&
                     (id_r != 8'd0)) begin
          phase_nxt  = PH_VALUE;
          count_nxt  = '0;
          int_nxt    = '0;
          frac_nxt   = '0;
          fdig_nxt   = '0;
          infrac_nxt = 1'b0;
          neg_nxt    = 1'b0;
        end else if (rx_byte == pacp_pkg::CH_HASH) begin
          id_nxt     = '0;
          count_nxt  = '0;
          int_nxt    = '0;
          frac_nxt   = '0;
          fdig_nxt   = '0;
          infrac_nxt = 1'b0;
          neg_nxt    = 1'b0;
        end else begin
          id_nxt    = '0;
          phase_nxt = PH_IDLE;
        end
      end
      PH_VALUE: begin
        if (value_end) begin
          phase_nxt  = (rx_byte == pacp_pkg::CH_HASH) ? PH_ID : PH_IDLE;
          id_nxt     = '0;
          count_nxt  = '0;
          int_nxt    = '0;
          frac_nxt   = '0;
          fdig_nxt   = '0;
          infrac_nxt = 1'b0;
          neg_nxt    = 1'b0;
        end else begin
          count_nxt = count_r + 5'd1;
          if (rx_byte == pacp_pkg::CH_MINUS) begin
            neg_nxt = 1'b1;
          end else if (rx_byte == pacp_pkg::CH_DOT) begin
            if (count_r != 5'd0) begin
              infrac_nxt = 1'b1;
            end
          end else if (is_digit) begin
            if (!infrac_r) begin
              int_nxt = (int_prod > {4'd0, pacp_pkg::INT_SAT}) ? pacp_pkg::INT_SAT
                                                               : int_prod[14:0];
            end else if (fdig_r < pacp_pkg::FRAC_DIGITS_MAX) begin
              frac_nxt = frac_r + {1'b0, pacp_pkg::frac_weight(fdig_r, digit)};
              fdig_nxt = fdig_r + 3'd1;
            end
          end
        end
      end
      default: begin
        if (rx_byte == pacp_pkg::CH_HASH) begin
          phase_nxt  = PH_ID;
          id_nxt     = '0;
          count_nxt  = '0;
          int_nxt    = '0;
          frac_nxt   = '0;
          fdig_nxt   = '0;
          infrac_nxt = 1'b0;
          neg_nxt    = 1'b0;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      id_r     <= '0;
      count_r  <= '0;
      int_r    <= '0;
      frac_r   <= '0;
      fdig_r   <= '0;
      infrac_r <= 1'b0;
      neg_r    <= 1'b0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      id_r     <= id_nxt;
      count_r  <= count_nxt;
      int_r    <= int_nxt;
      frac_r   <= frac_nxt;
      fdig_r   <= fdig_nxt;
      infrac_r <= infrac_nxt;
      neg_r    <= neg_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/pacp_out_reg.sv
`default_nettype none

module pacp_out_reg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,
  input  wire pacp_pkg::result_t   result,
  input  wire logic                out_stall,
  output logic                     out_free,
  output logic                     out_valid,
  output logic [7:0]               out_target_id,
  output logic signed [31:0]       out_param_value
);

  logic               valid_r;
  logic [7:0]         id_r;
  logic signed [31:0] value_r;

  assign out_free        = !valid_r || !out_stall;
  assign out_valid       = valid_r;
  assign out_target_id   = id_r;
  assign out_param_value = value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      id_r    <= result.id;
      value_r <= result.value;
    end
  end

endmodule

`default_nettype wire

// File: src/param_assign_command_parser_core.sv
// Parses "#[P]id=value!" commands from a stream of received ASCII bytes.
// Input channel: one byte per beat on in_rx_byte, qualified by in_valid and
// held off by in_stall. Output channel: one beat per completed command whose
// id lies in 1..MAX_ID, carrying out_target_id and out_param_value (Q16.16).
// A byte is first captured in an input register; from there it is
// parsed by single-pass logic and any result is written to the output register.
// A result reaches the receiver by way of the input register and then the
// output register, which holds it while the receiver stalls.
// One byte per cycle unless stalled; the parse state register is the only loop.
// When the receiver stalls, the held result stays on the output and bytes that
// complete no command keep flowing; a byte that would complete a command waits
// in the input register until the output register frees, stalling the input.
// Reset returns the parser to waiting for '#' and empties both registers.
`default_nettype none

module param_assign_command_parser_core #(
  parameter int unsigned MAX_ID      = pacp_pkg::MAX_ID_DEF,
  parameter int unsigned VALUE_CHARS = pacp_pkg::VALUE_CHARS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [7:0]          in_rx_byte,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [7:0]               out_target_id,
  output logic signed [31:0]       out_param_value
);

  `include "param_assign_command_parser_core_assert.svh"

  logic              byte_valid_r;
  logic [7:0]        byte_r;
  logic              out_free;
  logic              consume;
  logic              load;
  pacp_pkg::result_t result;

  assign consume  = byte_valid_r && (!result.emit || out_free);
  assign load     = consume && result.emit;
  assign in_stall = byte_valid_r && !consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_valid_r <= 1'b0;
    end else if (!in_stall) begin
      byte_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_rx_byte;
    end
  end

  pacp_parser #(
    .MAX_ID      (MAX_ID),
    .VALUE_CHARS (VALUE_CHARS)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (consume),
    .rx_byte (byte_r),
    .result  (result)
  );

  pacp_out_reg u_out_reg (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (load),
    .result          (result),
    .out_stall       (out_stall),
    .out_free        (out_free),
    .out_valid       (out_valid),
    .out_target_id   (out_target_id),
    .out_param_value (out_param_value)
  );

  `PACP_ASSERT_IMPLY(a_id_in_range, out_valid,
    (out_target_id != 8'd0) && (out_target_id <= 8'(MAX_ID)), "result id out of range")
  `PACP_ASSERT_IMPLY(a_no_overwrite, load, !(out_valid && out_stall),
    "result loaded over a stalled result")
  `PACP_ASSERT_IMPLY(a_stall_only_full, in_stall, byte_valid_r && result.emit,
    "input stalled without a pending result byte")
  `PACP_ASSERT_NEXT(a_load_shows, load, out_valid, "loaded result not presented")

endmodule

`default_nettype wire

// File: bench/param_assign_command_parser_core_test.sv
module param_assign_command_parser_core_test;

  localparam int unsigned MAX_ID_CFG = pacp_pkg::MAX_ID_DEF;
  localparam int unsigned VALUE_LIMIT = pacp_pkg::VALUE_CHARS_DEF;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef enum logic [1:0] {PH_WAIT, PH_ID, PH_VALUE, PH_SPARE} phase_t;

  typedef struct {
    logic [7:0]         id;
    logic signed [31:0] value;
  } param_write_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_target_id;
  logic signed [31:0] out_param_value;

  param_assign_command_parser_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_target_id(out_target_id),
    .out_param_value(out_param_value)
  );

  always #2 clk = ~clk;

  // Parser state as the block should hold it.
  phase_t      phase = PH_WAIT;
  logic [7:0]  id_acc = 8'd0;
  logic [4:0]  val_chars = 5'd0;
  logic [15:0] int_mag = 16'd0;
  logic [16:0] frac_acc = 17'd0;
  logic [2:0]  frac_cnt = 3'd0;
  logic        frac_mode = 1'b0;
  logic        neg = 1'b0;

  param_write_t pending_writes [$];
  logic [7:0]   cmd_bytes [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned items_sent = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  logic        long_hold = 1'b0;
  event        hold_go;

  function automatic void clear_value();
    val_chars = 5'd0;
    int_mag = 16'd0;
    frac_acc = 17'd0;
    frac_cnt = 3'd0;
    frac_mode = 1'b0;
    neg = 1'b0;
  endfunction

  function automatic logic [16:0] digit_weight(input int unsigned pos, input int unsigned d);
    int unsigned scale;
    scale = 10;
    repeat (pos) scale = scale * 10;
    return 17'((d << 16) / scale);
  endfunction

  task automatic parse_byte(input logic [7:0] c);
    logic         is_digit;
    int unsigned  d;
    int unsigned  grown;
    logic [31:0]  mag;
    param_write_t w;
    is_digit = (c >= pacp_pkg::CH_ZERO) && (c <= pacp_pkg::CH_NINE);
    d = c - pacp_pkg::CH_ZERO;
    case (phase)
      PH_ID: begin
        if (c == pacp_pkg::CH_UPPER_P || c == pacp_pkg::CH_LOWER_P) begin
        end else if (is_digit) begin
          id_acc = 8'(id_acc * 10 + d);
        end else if ((c == pacp_pkg::CH_EQUAL || c == pacp_pkg::CH_COLON) &&
                     id_acc != 8'd0) begin
          clear_value();
          phase = PH_VALUE;
        end else if (c == pacp_pkg::CH_HASH) begin
          id_acc = 8'd0;
          clear_value();
        end else begin
          id_acc = 8'd0;
          phase = PH_WAIT;
        end
      end
      PH_VALUE: begin
        if (c == pacp_pkg::CH_BANG || c == pacp_pkg::CH_HASH || val_chars >= VALUE_LIMIT) begin
          if (id_acc >= 1 && id_acc <= MAX_ID_CFG) begin
            mag = {int_mag, 16'h0000} + 32'(frac_acc);
            w.id = id_acc;
            w.value = neg ? -mag : mag;
            pending_writes.push_back(w);
          end
          id_acc = 8'd0;
          clear_value();
          phase = (c == pacp_pkg::CH_HASH) ? PH_ID : PH_WAIT;
        end else begin
          if (c == pacp_pkg::CH_MINUS) begin
            neg = 1'b1;
          end else if (c == pacp_pkg::CH_DOT) begin
            if (val_chars != 5'd0) frac_mode = 1'b1;
          end else if (is_digit) begin
            if (!frac_mode) begin
              grown = int_mag * 10 + d;
              int_mag = (grown > pacp_pkg::INT_SAT) ? 16'(pacp_pkg::INT_SAT) : 16'(grown);
            end else if (frac_cnt < pacp_pkg::FRAC_DIGITS_MAX) begin
              frac_acc = frac_acc + digit_weight(frac_cnt, d);
              frac_cnt = frac_cnt + 3'd1;
            end
          end
          val_chars = val_chars + 5'd1;
        end
      end
      default: begin
        if (c == pacp_pkg::CH_HASH) begin
          id_acc = 8'd0;
          clear_value();
          phase = PH_ID;
        end else begin
          phase = PH_WAIT;
        end
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_byte(b);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic void add_decimal(input int unsigned num);
    logic [7:0] text [$];
    do begin
      text.push_front(pacp_pkg::CH_ZERO + 8'(num % 10));
      num = num / 10;
    end while (num != 0);
    foreach (text[i]) cmd_bytes.push_back(text[i]);
  endfunction

  function automatic logic [7:0] random_digit();
    return pacp_pkg::CH_ZERO + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] random_value_char();
    logic [7:0] c;
    c = $urandom_range(1) ? random_digit() : 8'($urandom_range(255));
    if (c == pacp_pkg::CH_BANG || c == pacp_pkg::CH_HASH) c = pacp_pkg::CH_DOT;
    return c;
  endfunction

  task automatic send_command();
    int unsigned pick;
    logic [7:0]  junk;
    cmd_bytes = {};
    if ($urandom_range(7) == 0)
      repeat ($urandom_range(3, 1)) cmd_bytes.push_back(8'($urandom_range(255)));
    cmd_bytes.push_back(pacp_pkg::CH_HASH);
    pick = $urandom_range(19);
    if (pick == 0) begin
      cmd_bytes.push_back(pacp_pkg::CH_UPPER_P);
    end else if (pick == 1) begin
      cmd_bytes.push_back(pacp_pkg::CH_LOWER_P);
    end else if (pick == 2) begin
      add_decimal($urandom_range(99));
      cmd_bytes.push_back(pacp_pkg::CH_HASH);
    end
    pick = $urandom_range(9);
    if (pick == 7) begin
      add_decimal($urandom_range(255));
    end else if (pick == 8) begin
      add_decimal($urandom_range(9999, 256));
    end else begin
      add_decimal($urandom_range(MAX_ID_CFG, 1));
    end
    if (pick == 9) begin
      junk = 8'($urandom_range(255));
      if ((junk >= pacp_pkg::CH_ZERO && junk <= pacp_pkg::CH_NINE) ||
          junk == pacp_pkg::CH_UPPER_P || junk == pacp_pkg::CH_LOWER_P ||
          junk == pacp_pkg::CH_HASH || junk == pacp_pkg::CH_EQUAL ||
          junk == pacp_pkg::CH_COLON)
        junk = pacp_pkg::CH_MINUS;
      cmd_bytes.push_back(junk);
    end
    cmd_bytes.push_back($urandom_range(1) ? pacp_pkg::CH_EQUAL : pacp_pkg::CH_COLON);
    if ($urandom_range(15) == 0) begin
      repeat (VALUE_LIMIT) cmd_bytes.push_back(random_value_char());
      pick = $urandom_range(2);
      cmd_bytes.push_back(pick == 0 ? pacp_pkg::CH_BANG :
                          pick == 1 ? pacp_pkg::CH_HASH : 8'($urandom_range(255)));
    end else begin
      if ($urandom_range(3) == 0) cmd_bytes.push_back(pacp_pkg::CH_MINUS);
      if ($urandom_range(7) == 0) cmd_bytes.push_back(pacp_pkg::CH_DOT);
      repeat ($urandom_range(6)) cmd_bytes.push_back(random_digit());
      if ($urandom_range(1)) begin
        cmd_bytes.push_back(pacp_pkg::CH_DOT);
        repeat ($urandom_range(7)) cmd_bytes.push_back(random_digit());
      end
      if ($urandom_range(7) == 0) cmd_bytes.push_back(random_value_char());
      cmd_bytes.push_back($urandom_range(7) == 0 ? pacp_pkg::CH_HASH : pacp_pkg::CH_BANG);
    end
    foreach (cmd_bytes[i]) send_byte(cmd_bytes[i]);
  endtask

  task automatic check_result(input logic [7:0] got_id, input logic signed [31:0] got_value);
    param_write_t want;
    if (pending_writes.size() == 0) begin
      $error("unexpected beat: target_id %0d param_value %0d", got_id, got_value);
      error_count++;
    end else begin
      want = pending_writes.pop_front();
      if (got_id !== want.id) begin
        $error("target_id: expected %0d, actual %0d", want.id, got_id);
        error_count++;
      end
      if (got_value !== want.value) begin
        $error("param_value: expected %0d, actual %0d", want.value, got_value);
        error_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_target_id, out_param_value);
    out_stall <= long_hold || ($urandom_range(99) < recv_stall_pct);
  end

  always begin
    @(hold_go);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_idle_pct = 28;
    recv_stall_pct = 47;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("#16=99999.999999!");
    send_text("#P1:.5-#");
  endtask

  task automatic test_random(input int unsigned sender_pct, input int unsigned receiver_pct,
                             input int unsigned count);
    int unsigned stop_at;
    send_idle_pct = sender_pct;
    recv_stall_pct = receiver_pct;
    stop_at = items_sent + count;
    while (items_sent < stop_at) send_command();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    -> hold_go;
    for (int i = 1; i <= 12; i++) send_text($sformatf("#%0d=%0d.5!", i, i * 7));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(28, 47, 160);
    test_random(47, 28, 160);
    test_backpressure();
    test_random(0, 0, 160);
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_writes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
